// ----- design/fblc_pkg.sv -----
package fblc_pkg;

	localparam int WINDOW_DEPTH = 100;
	localparam int FORCE_W      = 32;
	localparam int GAIN_W       = 17;
	localparam int SUM_W        = 40;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int DSTEP_W      = $clog2(SUM_W + 1);
	localparam int HIST_W       = 2 * FORCE_W;
	localparam int PADDR_W      = 3;

	localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(40043);

	// register index, taken from paddr[2]
	localparam logic REG_FILTER_GAIN = 1'b0;

	typedef logic signed [FORCE_W-1:0] force_t;

	typedef struct packed {
		force_t x;
		force_t y;
		force_t z;
	} force_vec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILT,
		ST_DELTA,
		ST_SUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

endpackage

// ----- design/force_lpf_with_bias_calibration_unit.sv -----
// Three-axis force low-pass filter with sliding-window bias calibration.
//
// Sample channel: sample_valid/sample_ready carry raw_force_x/y/z (signed
// Q16.16) and the running flag. Result channel: result_valid/result_ready
// carry the filtered forces and the bias now held. One result per request.
// Configuration: APB-style write of filter_gain (Q1.16, clamped to one) at
// byte address 0; pready is tied high and prdata returns the register.
//
// A running request skips the window update and the divide. The next
// request can be accepted in the cycle after the result is loaded;
// calibration time is set by the 40-step bit-serial divider (one per axis,
// working in parallel) and the filter's single shared multiplier. The x/y
// history lives in one synchronous RAM, read at acceptance and written
// back in the cycle the new window sums are formed.
//
// Reset clears filter state, sums, fill count, slot and bias, and restores
// the default gain; no clearing pass runs, history entries are only used
// once the window is full. A stalled receiver holds the result register;
// the next request is still accepted and waits for the register to free.
module force_lpf_with_bias_calibration_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic signed [31:0]            raw_force_x,
	input  logic signed [31:0]            raw_force_y,
	input  logic signed [31:0]            raw_force_z,
	input  logic                          running,
	// result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [31:0]            force_x_out,
	output logic signed [31:0]            force_y_out,
	output logic signed [31:0]            force_z_out,
	output logic signed [31:0]            bias_x_out,
	output logic signed [31:0]            bias_y_out,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fblc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	fblc_pkg::state_t                  state_q;
	fblc_pkg::state_t                  state_d;
	logic [fblc_pkg::GAIN_W-1:0]       gain_q;
	logic                              running_q;
	logic signed [fblc_pkg::SUM_W-1:0] sum_x_q;
	logic signed [fblc_pkg::SUM_W-1:0] sum_y_q;
	logic [fblc_pkg::CNT_W-1:0]        fill_q;
	logic [fblc_pkg::SLOT_W-1:0]       slot_q;
	fblc_pkg::force_t                  bias_x_q;
	fblc_pkg::force_t                  bias_y_q;
	logic signed [32:0]                dx_q;
	logic signed [32:0]                dy_q;
	logic                              result_valid_q;
	fblc_pkg::force_t                  force_x_q;
	fblc_pkg::force_t                  force_y_q;
	fblc_pkg::force_t                  force_z_q;
	fblc_pkg::force_t                  bias_x_out_q;
	fblc_pkg::force_t                  bias_y_out_q;

	logic                              sample_take;
	logic                              cfg_write;
	logic                              lpf_done;
	logic                              div_start;
	logic                              div_done_x;
	logic                              div_done_y;
	logic                              ram_we;
	logic                              load_out;
	logic                              win_full;
	fblc_pkg::force_vec_t              raw_vec;
	fblc_pkg::force_vec_t              filt_vec;
	fblc_pkg::force_t                  quot_x;
	fblc_pkg::force_t                  quot_y;
	logic [fblc_pkg::HIST_W-1:0]       hist_rdata;
	fblc_pkg::force_t                  old_x;
	fblc_pkg::force_t                  old_y;
	logic signed [32:0]                sub_x;
	logic signed [32:0]                sub_y;
	fblc_pkg::force_t                  sat_x;
	fblc_pkg::force_t                  sat_y;

	assign sample_ready = (state_q == fblc_pkg::ST_IDLE);
	assign sample_take  = sample_valid && sample_ready;
	assign cfg_write    = psel && penable && pwrite && (paddr[2] == fblc_pkg::REG_FILTER_GAIN);
	assign pready       = 1'b1;
	assign prdata       = (paddr[2] == fblc_pkg::REG_FILTER_GAIN) ? {15'd0, gain_q} : 32'd0;
	assign win_full     = (fill_q == fblc_pkg::CNT_W'(fblc_pkg::WINDOW_DEPTH));

	assign raw_vec.x = raw_force_x;
	assign raw_vec.y = raw_force_y;
	assign raw_vec.z = raw_force_z;
	assign old_x     = hist_rdata[fblc_pkg::HIST_W-1:fblc_pkg::FORCE_W];
	assign old_y     = hist_rdata[fblc_pkg::FORCE_W-1:0];

	// Filter unit: one shared multiplier walks x, y, z.
	fblc_lpf u_lpf (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sample_take),
		.gain   (gain_q),
		.raw    (raw_vec),
		.done   (lpf_done),
		.filt   (filt_vec)
	);

	// History window; the oldest slot is fetched at acceptance so it is
	// ready by the time the filter finishes.
	fblc_ram #(
		.DEPTH (fblc_pkg::WINDOW_DEPTH),
		.WIDTH (fblc_pkg::HIST_W),
		.AW    (fblc_pkg::SLOT_W)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata ({filt_vec.x, filt_vec.y}),
		.re    (sample_take),
		.raddr (slot_q),
		.rdata (hist_rdata)
	);

	fblc_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_x_q),
		.divisor  (fill_q),
		.done     (div_done_x),
		.quotient (quot_x)
	);

	fblc_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_y_q),
		.divisor  (fill_q),
		.done     (div_done_y),
		.quotient (quot_y)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fblc_pkg::ST_IDLE: begin
				if (sample_take) state_d = fblc_pkg::ST_FILT;
			end
			fblc_pkg::ST_FILT: begin
				if (lpf_done) state_d = running_q ? fblc_pkg::ST_OUT : fblc_pkg::ST_DELTA;
			end
			fblc_pkg::ST_DELTA:   state_d = fblc_pkg::ST_SUM;
			fblc_pkg::ST_SUM:     state_d = fblc_pkg::ST_DIV_GO;
			fblc_pkg::ST_DIV_GO:  state_d = fblc_pkg::ST_DIV_WAIT;
			fblc_pkg::ST_DIV_WAIT: begin
				if (div_done_x) state_d = fblc_pkg::ST_OUT;
			end
			fblc_pkg::ST_OUT: begin
				if (!result_valid_q || result_ready) state_d = fblc_pkg::ST_IDLE;
			end
			default: state_d = fblc_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		ram_we    = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			fblc_pkg::ST_SUM:    ram_we    = 1'b1;
			fblc_pkg::ST_DIV_GO: div_start = 1'b1;
			fblc_pkg::ST_OUT:    load_out  = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	// Saturating bias removal.
	always_comb begin
		sub_x = {filt_vec.x[31], filt_vec.x} - {bias_x_q[31], bias_x_q};
		sub_y = {filt_vec.y[31], filt_vec.y} - {bias_y_q[31], bias_y_q};
		if (sub_x[32] != sub_x[31]) begin
			sat_x = sub_x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat_x = sub_x[31:0];
		end
		if (sub_y[32] != sub_y[31]) begin
			sat_y = sub_y[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat_y = sub_y[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= fblc_pkg::ST_IDLE;
			gain_q         <= fblc_pkg::GAIN_RESET;
			running_q      <= 1'b0;
			sum_x_q        <= '0;
			sum_y_q        <= '0;
			fill_q         <= '0;
			slot_q         <= '0;
			bias_x_q       <= '0;
			bias_y_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				gain_q <= pwdata[fblc_pkg::GAIN_W-1:0];
			end
			if (sample_take) begin
				running_q <= running;
			end
			// fold in the new sample, drop the evicted one
			if (state_q == fblc_pkg::ST_SUM) begin
				sum_x_q <= sum_x_q + fblc_pkg::SUM_W'(dx_q);
				sum_y_q <= sum_y_q + fblc_pkg::SUM_W'(dy_q);
				if (!win_full) begin
					fill_q <= fill_q + 1'b1;
				end
				if (slot_q == fblc_pkg::SLOT_W'(fblc_pkg::WINDOW_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (state_q == fblc_pkg::ST_DIV_WAIT && div_done_x) begin
				bias_x_q <= quot_x;
				bias_y_q <= quot_y;
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Window deltas and the result register carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == fblc_pkg::ST_DELTA) begin
			dx_q <= win_full ? ({filt_vec.x[31], filt_vec.x} - {old_x[31], old_x})
			                 : {filt_vec.x[31], filt_vec.x};
			dy_q <= win_full ? ({filt_vec.y[31], filt_vec.y} - {old_y[31], old_y})
			                 : {filt_vec.y[31], filt_vec.y};
		end
		if (load_out) begin
			force_x_q    <= running_q ? sat_x : '0;
			force_y_q    <= running_q ? sat_y : '0;
			force_z_q    <= filt_vec.z;
			bias_x_out_q <= bias_x_q;
			bias_y_out_q <= bias_y_q;
		end
	end

	assign result_valid = result_valid_q;
	assign force_x_out  = force_x_q;
	assign force_y_out  = force_y_q;
	assign force_z_out  = force_z_q;
	assign bias_x_out   = bias_x_out_q;
	assign bias_y_out   = bias_y_out_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= fblc_pkg::CNT_W'(fblc_pkg::WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= fblc_pkg::SLOT_W'(fblc_pkg::WINDOW_DEPTH - 1))
		else $error("write slot beyond window");

	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done_x == div_done_y) && (!div_done_x || state_q == fblc_pkg::ST_DIV_WAIT))
		else $error("divider completion out of step");

	a_lpf_done: assert property (@(posedge clk) disable iff (!arst_n)
		lpf_done |-> state_q == fblc_pkg::ST_FILT)
		else $error("filter completion outside filter wait");

	a_no_write_running: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !running_q)
		else $error("history written in running mode");
`endif

endmodule

// ----- design/fblc_ram.sv -----
module fblc_ram #(
	parameter int DEPTH = 100,
	parameter int WIDTH = 64,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/fblc_lpf.sv -----
module fblc_lpf (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [fblc_pkg::GAIN_W-1:0]      gain,
	input  fblc_pkg::force_vec_t             raw,
	output logic                             done,
	output fblc_pkg::force_vec_t             filt
);

	fblc_pkg::force_vec_t              raw_q;
	logic [fblc_pkg::GAIN_W-1:0]       gain_q;
	logic                              busy_q;
	logic                              phase_q;
	logic [1:0]                        axis_q;
	logic                              done_q;
	fblc_pkg::force_t                  filt_q [3];
	logic signed [50:0]                prod_s1;

	fblc_pkg::force_t    raw_sel;
	fblc_pkg::force_t    filt_sel;
	logic signed [32:0]  diff;
	logic signed [50:0]  rnd;
	logic signed [50:0]  step;
	logic signed [34:0]  fnew;

	always_comb begin
		case (axis_q)
			2'd0:    raw_sel = raw_q.x;
			2'd1:    raw_sel = raw_q.y;
			default: raw_sel = raw_q.z;
		endcase
		filt_sel = filt_q[axis_q];
		diff     = {raw_sel[31], raw_sel} - {filt_sel[31], filt_sel};
		// f + floor((a*(in - f) + half) / 2^16)
		rnd      = prod_s1 + 51'sd32768;
		step     = rnd >>> 16;
		fnew     = {{3{filt_sel[31]}}, filt_sel} + step[34:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			phase_q   <= 1'b0;
			axis_q    <= 2'd0;
			done_q    <= 1'b0;
			filt_q[0] <= '0;
			filt_q[1] <= '0;
			filt_q[2] <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				axis_q  <= 2'd0;
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					filt_q[axis_q] <= fnew[31:0];
					if (axis_q == 2'd2) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
			end
		end
	end

	// sample and clamped gain are latched once per request
	always_ff @(posedge clk) begin
		if (start) begin
			raw_q  <= raw;
			gain_q <= (gain > fblc_pkg::GAIN_ONE) ? fblc_pkg::GAIN_ONE : gain;
		end
		if (busy_q && !phase_q) begin
			prod_s1 <= $signed({1'b0, gain_q}) * diff;
		end
	end

	assign done   = done_q;
	assign filt.x = filt_q[0];
	assign filt.y = filt_q[1];
	assign filt.z = filt_q[2];

endmodule

// ----- design/fblc_div.sv -----
module fblc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [fblc_pkg::SUM_W-1:0] dividend,
	input  logic [fblc_pkg::CNT_W-1:0]       divisor,
	output logic                             done,
	output fblc_pkg::force_t                 quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [fblc_pkg::DSTEP_W-1:0]      cnt_q;
	logic                              neg_q;
	logic [fblc_pkg::SUM_W-1:0]        work_q;
	logic [fblc_pkg::CNT_W-1:0]        rem_q;
	logic [fblc_pkg::CNT_W-1:0]        div_q;
	fblc_pkg::force_t                  quot_q;

	logic [fblc_pkg::SUM_W-1:0]        mag;
	logic [fblc_pkg::CNT_W:0]          rem_sh;
	logic                              ge;
	logic [fblc_pkg::CNT_W:0]          rem_diff;
	logic [fblc_pkg::SUM_W-1:0]        qmag;

	always_comb begin
		mag      = dividend[fblc_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
		rem_sh   = {rem_q, work_q[fblc_pkg::SUM_W-1]};
		ge       = rem_sh >= {1'b0, div_q};
		rem_diff = rem_sh - {1'b0, div_q};
		qmag     = {work_q[fblc_pkg::SUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == fblc_pkg::DSTEP_W'(fblc_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division on magnitudes, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= dividend[fblc_pkg::SUM_W-1];
			work_q <= mag;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			work_q <= qmag;
			rem_q  <= ge ? rem_diff[fblc_pkg::CNT_W-1:0] : rem_sh[fblc_pkg::CNT_W-1:0];
			if (cnt_q == fblc_pkg::DSTEP_W'(fblc_pkg::SUM_W - 1)) begin
				quot_q <= neg_q ? (~qmag[31:0] + 1'b1) : qmag[31:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- tb/force_lpf_with_bias_calibration_unit_tb.sv -----
`timescale 1ns / 1ps

module force_lpf_with_bias_calibration_unit_tb;

	typedef fblc_pkg::force_t force_t;

	localparam force_t F_MAX = 32'sh7fff_ffff;
	localparam force_t F_MIN = 32'sh8000_0000;
	// settle time at the end, a little longer than a calibrating request takes
	localparam int SETTLE_CYCLES = 60;

	// one request as the sender holds it
	typedef struct packed {
		force_t x;
		force_t y;
		force_t z;
		logic   subtract_bias;
		logic   hold;          // hold back until all results are in
	} sample_t;

	typedef struct packed {
		force_t fx;
		force_t fy;
		force_t fz;
		force_t bx;
		force_t by;
	} outputs_t;

	typedef enum int {PACE_FREE, PACE_COIN, PACE_LONG} pace_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_ready;
	force_t             raw_force_x = '0;
	force_t             raw_force_y = '0;
	force_t             raw_force_z = '0;
	logic               running = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	force_t             force_x_out;
	force_t             force_y_out;
	force_t             force_z_out;
	force_t             bias_x_out;
	force_t             bias_y_out;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [fblc_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// filter and calibration state as the block should hold it
	logic [fblc_pkg::GAIN_W-1:0] gain_reg = fblc_pkg::GAIN_RESET;
	force_t             filt_x = '0;
	force_t             filt_y = '0;
	force_t             filt_z = '0;
	force_t             hist_x [fblc_pkg::WINDOW_DEPTH];
	force_t             hist_y [fblc_pkg::WINDOW_DEPTH];
	longint             sum_x = 0;
	longint             sum_y = 0;
	int                 fill_count = 0;
	int                 write_slot = 0;
	force_t             bias_x = '0;
	force_t             bias_y = '0;

	sample_t            sample_backlog [$];
	outputs_t           awaited_outputs [$];
	sample_t            on_wire;
	bit                 request_open = 1'b0;

	int                 mismatches = 0;
	int                 cal_count = 0;
	int                 run_count = 0;
	int                 sat_count = 0;
	int                 wraps = 0;
	int                 gain_settings = 1;

	int                 burst_left = 0;
	int                 gap_left = 0;
	pace_t              pace = PACE_FREE;
	int                 pace_left = 0;
	int                 stall_left = 0;

	force_lpf_with_bias_calibration_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.raw_force_x  (raw_force_x),
		.raw_force_y  (raw_force_y),
		.raw_force_z  (raw_force_z),
		.running      (running),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.force_x_out  (force_x_out),
		.force_y_out  (force_y_out),
		.force_z_out  (force_z_out),
		.bias_x_out   (bias_x_out),
		.bias_y_out   (bias_y_out),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// One low-pass step: a*in + (1-a)*prev, rounded half up by adding half an
	// LSB and flooring (arithmetic shift floors).
	function automatic force_t smooth(force_t raw, force_t prev,
					  logic [fblc_pkg::GAIN_W-1:0] g);
		longint a;
		longint acc;
		a = g;
		acc = a * raw + (65536 - a) * prev + 32768;
		return force_t'(acc >>> 16);
	endfunction

	// Remove the held bias, clamping to the signed 32-bit range.
	function automatic force_t debias(force_t f, force_t b);
		longint d;
		d = longint'(f) - longint'(b);
		if (d > longint'(F_MAX)) begin
			sat_count++;
			return F_MAX;
		end
		if (d < longint'(F_MIN)) begin
			sat_count++;
			return F_MIN;
		end
		return force_t'(d);
	endfunction

	// Advance the expected state by one accepted request and queue its result.
	task automatic track_force_filter(input sample_t s);
		outputs_t                    o;
		logic [fblc_pkg::GAIN_W-1:0] g;
		g = (gain_reg > fblc_pkg::GAIN_ONE) ? fblc_pkg::GAIN_ONE : gain_reg;
		filt_x = smooth(s.x, filt_x, g);
		filt_y = smooth(s.y, filt_y, g);
		filt_z = smooth(s.z, filt_z, g);
		if (s.subtract_bias) begin
			o.fx = debias(filt_x, bias_x);
			o.fy = debias(filt_y, bias_y);
			run_count++;
		end else begin
			// full window: retire the oldest entry before overwriting it
			if (fill_count >= fblc_pkg::WINDOW_DEPTH) begin
				sum_x -= hist_x[write_slot];
				sum_y -= hist_y[write_slot];
			end else begin
				fill_count++;
			end
			hist_x[write_slot] = filt_x;
			hist_y[write_slot] = filt_y;
			sum_x += filt_x;
			sum_y += filt_y;
			write_slot = (write_slot + 1) % fblc_pkg::WINDOW_DEPTH;
			if (write_slot == 0)
				wraps++;
			// signed divide truncates toward zero
			bias_x = force_t'(sum_x / fill_count);
			bias_y = force_t'(sum_y / fill_count);
			o.fx = '0;
			o.fy = '0;
			cal_count++;
		end
		o.fz = filt_z;
		o.bx = bias_x;
		o.by = bias_y;
		awaited_outputs.push_back(o);
	endtask

	function automatic void compare_field(string name, force_t want, force_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Queue one request; now and then mark it to hold until the pipe drains.
	task automatic push_sample(force_t x, force_t y, force_t z, logic subtract);
		sample_t s;
		s.x = x;
		s.y = y;
		s.z = z;
		s.subtract_bias = subtract;
		s.hold = ($urandom_range(0, 49) == 0);
		sample_backlog.push_back(s);
	endtask

	// Mostly values scattered around a working point, with extremes and
	// fully random words mixed in.
	function automatic force_t pick_force(force_t centre, int shift);
		int     r;
		force_t n;
		r = $urandom_range(0, 19);
		if (r == 0)
			return F_MAX;
		if (r == 1)
			return F_MIN;
		if (r == 2)
			return '0;
		if (r == 3)
			return -1;
		if (r <= 6)
			return force_t'($urandom);
		n = $urandom;
		n = n >>> shift;
		return centre + n;
	endfunction

	// Alternate calibration and running stretches, each around its own
	// working point. A few requests flip the mode to break the pattern.
	task automatic queue_random_phase(int n);
		int     left;
		int     runlen;
		int     shift;
		bit     calib;
		bit     mode;
		force_t cx;
		force_t cy;
		force_t cz;
		left = n;
		calib = 1'b1;
		while (left > 0) begin
			shift = $urandom_range(4, 28);
			cx = ($urandom_range(0, 2) == 0) ? force_t'($urandom) : force_t'($urandom) >>> 10;
			cy = ($urandom_range(0, 2) == 0) ? force_t'($urandom) : force_t'($urandom) >>> 10;
			cz = force_t'($urandom) >>> $urandom_range(0, 16);
			if (calib)
				runlen = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 130)
								     : $urandom_range(1, 30);
			else
				runlen = $urandom_range(1, 40);
			if (runlen > left)
				runlen = left;
			repeat (runlen) begin
				mode = !calib;
				if ($urandom_range(0, 9) == 0)
					mode = !mode;
				push_sample(pick_force(cx, shift), pick_force(cy, shift),
					    pick_force(cz, shift), mode);
			end
			left -= runlen;
			calib = !calib;
		end
	endtask

	task automatic wait_for_drain();
		while (sample_backlog.size() != 0 || request_open || awaited_outputs.size() != 0)
			@(posedge clk);
	endtask

	// Gain writes only go out with the block idle: every result collected.
	task automatic set_gain(input logic [fblc_pkg::GAIN_W-1:0] value);
		wait_for_drain();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {fblc_pkg::REG_FILTER_GAIN, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		gain_reg = value;
		gain_settings++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Sender: present requests from the backlog in bursts with random gaps.
	// Valid and payload hold until accepted.
	always @(posedge clk) begin : drive_samples
		bit fired;
		bit can_issue;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			fired = sample_valid && sample_ready;
			if (fired) begin
				track_force_filter(on_wire);
				request_open = 1'b0;
			end
			if (sample_valid && !fired) begin
				// hold the current request
			end else if (gap_left > 0) begin
				gap_left--;
				sample_valid <= 1'b0;
			end else begin
				can_issue = (sample_backlog.size() > 0);
				// drain everything before a held request goes out
				if (can_issue && sample_backlog[0].hold)
					can_issue = (awaited_outputs.size() == 0);
				if (can_issue) begin
					on_wire = sample_backlog.pop_front();
					request_open = 1'b1;
					raw_force_x  <= on_wire.x;
					raw_force_y  <= on_wire.y;
					raw_force_z  <= on_wire.z;
					running      <= on_wire.subtract_bias;
					sample_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switch between free flow, coin-flip stalls and long stalls.
	always @(posedge clk) begin : pace_results
		bit take;
		if (pace_left == 0) begin
			pace = pace_t'($urandom_range(0, 2));
			pace_left = $urandom_range(50, 400);
		end else begin
			pace_left--;
		end
		case (pace)
		PACE_FREE: begin
			take = 1'b1;
		end
		PACE_COIN: begin
			take = $urandom_range(0, 1);
		end
		default: begin
			if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else begin
				take = 1'b1;
				if ($urandom_range(0, 19) == 0)
					stall_left = $urandom_range(1, 120);
			end
		end
		endcase
		result_ready <= take;
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin : check_results
		outputs_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_outputs.size() == 0) begin
				$error("result with nothing outstanding: x=%0d y=%0d z=%0d",
				       force_x_out, force_y_out, force_z_out);
				mismatches++;
			end else begin
				want = awaited_outputs.pop_front();
				compare_field("force_x_out", want.fx, force_x_out);
				compare_field("force_y_out", want.fy, force_y_out);
				compare_field("force_z_out", want.fz, force_z_out);
				compare_field("bias_x_out", want.bx, bias_x_out);
				compare_field("bias_y_out", want.by, bias_y_out);
			end
		end
	end

	initial begin : run_test
		logic [fblc_pkg::GAIN_W-1:0] g;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes and both modes at the reset gain
		push_sample('0, '0, '0, 1'b0);
		push_sample(F_MAX, F_MIN, F_MAX, 1'b0);
		push_sample(F_MIN, F_MAX, F_MIN, 1'b0);
		push_sample(F_MAX, F_MAX, F_MIN, 1'b1);
		push_sample(F_MIN, F_MIN, F_MAX, 1'b1);
		push_sample(-1, 1, -1, 1'b0);
		push_sample(1, -1, 1, 1'b1);
		push_sample(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 1'b0);

		// unity gain passes input straight through the filter
		set_gain(fblc_pkg::GAIN_ONE);
		push_sample(F_MAX, F_MIN, F_MAX, 1'b0);
		push_sample(F_MAX, F_MIN, F_MAX, 1'b0);
		push_sample(F_MAX, F_MIN, F_MIN, 1'b0);
		push_sample(F_MIN, F_MAX, F_MIN, 1'b1);
		push_sample(F_MAX, F_MIN, '0, 1'b1);

		// gain above one must clamp to one
		set_gain('1);
		push_sample(F_MIN, F_MAX, F_MAX, 1'b0);
		push_sample(12345, -54321, F_MIN, 1'b1);
		push_sample(F_MAX, F_MAX, F_MAX, 1'b0);

		// zero gain freezes the filter
		set_gain('0);
		push_sample(F_MAX, F_MIN, F_MAX, 1'b0);
		push_sample(F_MIN, F_MAX, F_MIN, 1'b1);
		push_sample(-1, -1, -1, 1'b0);

		set_gain(fblc_pkg::GAIN_W'(1));
		push_sample(F_MIN, F_MAX, F_MIN, 1'b0);
		push_sample(F_MAX, F_MIN, F_MAX, 1'b1);

		// Fill the window near the rails, then run with the opposite rails
		// so the bias subtraction saturates both ways.
		set_gain(fblc_pkg::GAIN_ONE);
		repeat (120)
			push_sample(F_MAX - $urandom_range(0, 255), F_MIN + $urandom_range(0, 255),
				    force_t'($urandom), 1'b0);
		repeat (30)
			push_sample(F_MIN + $urandom_range(0, 255), F_MAX - $urandom_range(0, 255),
				    force_t'($urandom), 1'b1);

		// random phases across a spread of gains, rails among them
		for (int i = 0; i < 10; i++) begin
			case (i)
			0: g = fblc_pkg::GAIN_RESET;
			1: g = '0;
			2: g = '1;
			3: g = fblc_pkg::GAIN_W'(65535);
			4: g = fblc_pkg::GAIN_W'(1);
			5: g = fblc_pkg::GAIN_W'(32768);
			default: g = $urandom_range(0, 131071);
			endcase
			set_gain(g);
			queue_random_phase(150);
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests (%0d calibrating, %0d running) over %0d gain settings",
			 cal_count + run_count, cal_count, run_count, gain_settings);
		$display("bias window wrapped %0d times, %0d x/y outputs clamped", wraps, sat_count);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#40ms;
		$display("timeout with %0d results outstanding", awaited_outputs.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
